FILE: src/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// shared types and constants of the 5x5 bayer demosaic
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int ROW_W      = 14;
  localparam int GEOM_W     = 14;
  localparam int SLOTS      = 8;
  localparam int SLOT_W     = 3;
  localparam int WIN        = 5;
  localparam int ACC_W      = 24;
  localparam int OUT_W      = 16;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_CFA_PATTERN  = 3'd1,
    CFG_BIT_DEPTH    = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] raw_pixel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic first_col;
    logic second_col;
    logic last_col;
    logic next_last_col;
    logic odd_row;
    logic odd_col;
    logic frame_last;
  } pos_flags_t;

  function automatic logic [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] x,
                                                input logic [OUT_W-1:0] maxv);
    logic [ACC_W-6:0] v;
    logic [OUT_W-1:0] res;
    v = x[ACC_W-2:4];
    if (x[ACC_W-1]) begin
      res = '0;
    end else if (v > (ACC_W-5)'(maxv)) begin
      res = maxv;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/bayer_demosaic_5x5.sv
// ----------------------------------------------------------------------------
// bayer_demosaic_5x5
// malvar-he-cutler 5x5 demosaic of a raster bayer stream with mirrored borders
// ----------------------------------------------------------------------------
// Takes one item per clock with no bubbles while in_stall is low. A result
// leaves through the line ram read, the shift of the column into the 5x5
// window and the kernels, then the output queue. In stream terms a result
// lags its raw pixel by 2*width+2 items; flush items drain the frame tail.
// Eight line rams, one per row slot, are read once per beat at one column; a
// small output queue lets input continue while results wait. The line rams
// need no clearing after reset.
module bayer_demosaic_5x5 #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bdm_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bdm_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bdm_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = $clog2(2 * MAX_WIDTH + 4);
  localparam logic [GEOM_W-1:0] MAX_W = GEOM_W'(MAX_WIDTH);

  // configuration
  logic              enable_r;
  logic [1:0]        cfa_r;
  logic [4:0]        bit_depth_r;
  logic [12:0]       frame_width_r;
  logic [13:0]       frame_height_r;
  logic              restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      cfa_r          <= 2'd0;
      bit_depth_r    <= 5'd12;
      frame_width_r  <= 13'd1920;
      frame_height_r <= 14'd1080;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:       enable_r       <= cfg_wdata[0];
        CFG_CFA_PATTERN:  cfa_r          <= cfg_wdata[1:0];
        CFG_BIT_DEPTH:    bit_depth_r    <= cfg_wdata[4:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  logic [GEOM_W-1:0] eff_w, eff_h;

  always_comb begin
    eff_w = {1'b0, frame_width_r};
    if (eff_w < GEOM_W'(3)) begin
      eff_w = GEOM_W'(3);
    end else if (eff_w > MAX_W) begin
      eff_w = MAX_W;
    end
    eff_h = (frame_height_r < 14'd3) ? GEOM_W'(3) : frame_height_r;
  end

  // position tracking
  logic [CW-1:0]     in_col_r, out_col_r, f_col_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r, f_row_r;
  logic [SLOT_W-1:0] in_slot_r, f_slot_r;
  logic [PW-1:0]     pending_r;
  logic [1:0]        ahead_r;

  logic              accept, is_raw, emit;
  logic              in_col_end, in_row_end, out_col_end, out_row_end;
  logic              f_col_end, f_row_end, in_frame_done, out_frame_done;
  logic [PW-1:0]     pending_pre, pending_nxt, thresh;
  logic [1:0]        ahead_pre, ahead_nxt;

  assign accept         = in_valid && !in_stall;
  assign is_raw         = accept && (in_item.operation == OP_PIXEL);
  assign in_col_end     = (GEOM_W'(in_col_r) + GEOM_W'(1)) == eff_w;
  assign in_row_end     = (in_row_r + ROW_W'(1)) == eff_h;
  assign out_col_end    = (GEOM_W'(out_col_r) + GEOM_W'(1)) == eff_w;
  assign out_row_end    = (out_row_r + ROW_W'(1)) == eff_h;
  assign f_col_end      = (GEOM_W'(f_col_r) + GEOM_W'(1)) == eff_w;
  assign f_row_end      = (f_row_r + ROW_W'(1)) == eff_h;
  assign in_frame_done  = is_raw && in_col_end && in_row_end;
  assign pending_pre    = pending_r + PW'(is_raw);
  assign ahead_pre      = ahead_r + 2'(in_frame_done);
  assign thresh         = PW'({1'b0, eff_w, 1'b1} + 16'd2);
  assign emit           = accept && (pending_pre >= thresh || ahead_pre != 2'd0);
  assign out_frame_done = emit && out_col_end && out_row_end;
  assign pending_nxt    = pending_pre - PW'(emit);
  assign ahead_nxt      = ahead_pre - 2'(out_frame_done);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      f_col_r   <= CW'(2);
      f_row_r   <= '0;
      f_slot_r  <= '0;
      pending_r <= '0;
      ahead_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      ahead_r   <= ahead_nxt;
      if (is_raw) begin
        if (in_col_end) begin
          in_col_r  <= '0;
          in_slot_r <= in_slot_r + SLOT_W'(1);
          in_row_r  <= in_row_end ? '0 : in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_r <= '0;
          out_row_r <= out_row_end ? '0 : out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
        if (f_col_end) begin
          f_col_r  <= '0;
          f_slot_r <= f_slot_r + SLOT_W'(1);
          f_row_r  <= f_row_end ? '0 : f_row_r + ROW_W'(1);
        end else begin
          f_col_r <= f_col_r + CW'(1);
        end
      end
    end
  end

  // row slot selection for the fetched column, mirrored at top and bottom
  logic [SLOT_W-1:0] sel [WIN];

  always_comb begin
    logic signed [15:0] rr;
    logic signed [15:0] hh;
    logic signed [15:0] fr;
    logic signed [15:0] off;
    hh = $signed({2'b00, eff_h});
    fr = $signed({2'b00, f_row_r});
    for (int i = 0; i < WIN; i++) begin
      rr = fr - 16'sd2 + 16'(i);
      if (rr < 16'sd0) begin
        rr = -rr;
      end else if (rr >= hh) begin
        rr = (hh <<< 1) - 16'sd2 - rr;
      end
      off    = rr - fr;
      sel[i] = f_slot_r + off[SLOT_W-1:0];
    end
  end

  // line rams
  logic [PIXEL_BITS-1:0] ram_q [SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_line
    bdm_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (is_raw && in_slot_r == SLOT_W'(k)),
      .waddr (in_col_r),
      .wdata (in_item.raw_pixel[PIXEL_BITS-1:0]),
      .raddr (f_col_r),
      .rdata (ram_q[k])
    );
  end

  // first two columns of rows 0..2, needed at the start of a frame
  logic [PIXEL_BITS-1:0] cap_r [3][2];

  always_ff @(posedge clk) begin
    if (is_raw && in_row_r < ROW_W'(3) && in_col_r < CW'(2)) begin
      cap_r[in_row_r[1:0]][in_col_r[0]] <= in_item.raw_pixel[PIXEL_BITS-1:0];
    end
  end

  // stage 1: ram read in flight
  logic                  s1_valid_r, s1_cap_r, s1_byp_hit_r;
  logic [SLOT_W-1:0]     s1_sel_r [WIN];
  logic [SLOT_W-1:0]     s1_byp_slot_r;
  logic [PIXEL_BITS-1:0] s1_byp_data_r;
  pos_flags_t            s1_flags_r, flags;

  always_comb begin
    flags.first_col     = out_col_r == '0;
    flags.second_col    = out_col_r == CW'(1);
    flags.last_col      = out_col_end;
    flags.next_last_col = (GEOM_W'(out_col_r) + GEOM_W'(2)) == eff_w;
    flags.odd_row       = out_row_r[0] ^ cfa_r[1];
    flags.odd_col       = out_col_r[0] ^ cfa_r[0] ^ cfa_r[1];
    flags.frame_last    = out_col_end && out_row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel_r      <= sel;
    s1_cap_r      <= out_row_r == '0 && out_col_r == '0;
    s1_flags_r    <= flags;
    s1_byp_hit_r  <= is_raw && in_col_r == f_col_r;
    s1_byp_slot_r <= in_slot_r;
    s1_byp_data_r <= in_item.raw_pixel[PIXEL_BITS-1:0];
  end

  // stage 2: column history
  logic [PIXEL_BITS-1:0] slot_q  [SLOTS];
  logic [PIXEL_BITS-1:0] col_new [WIN];
  logic [PIXEL_BITS-1:0] cap0    [WIN];
  logic [PIXEL_BITS-1:0] cap1    [WIN];
  logic [PIXEL_BITS-1:0] h_r     [WIN][WIN];
  logic                  s2_valid_r;
  pos_flags_t            s2_flags_r;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_q[k] = (s1_byp_hit_r && s1_byp_slot_r == SLOT_W'(k)) ? s1_byp_data_r : ram_q[k];
    end
    for (int i = 0; i < WIN; i++) begin
      col_new[i] = slot_q[s1_sel_r[i]];
    end
    cap0[0] = cap_r[2][0];
    cap0[1] = cap_r[1][0];
    cap0[2] = cap_r[0][0];
    cap0[3] = cap_r[1][0];
    cap0[4] = cap_r[2][0];
    cap1[0] = cap_r[2][1];
    cap1[1] = cap_r[1][1];
    cap1[2] = cap_r[0][1];
    cap1[3] = cap_r[1][1];
    cap1[4] = cap_r[2][1];
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      h_r[0] <= col_new;
      h_r[1] <= s1_cap_r ? cap1 : h_r[0];
      h_r[2] <= s1_cap_r ? cap0 : h_r[1];
      h_r[3] <= h_r[2];
      h_r[4] <= h_r[3];
    end
    s2_flags_r <= s1_flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage 3: kernels
  logic [PIXEL_BITS-1:0]   win [WIN][WIN];
  logic signed [ACC_W-1:0] wv  [WIN][WIN];
  logic signed [ACC_W-1:0] cen, far4, near4, diag, tg, t_oth, t_row, t_col;
  logic [4:0]              bd;
  logic [OUT_W:0]          maxv17;
  logic [OUT_W-1:0]        maxv, f_cen, f_tg, f_oth, f_row, f_col;
  out_item_t               result;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      win[i][0] = s2_flags_r.first_col  ? h_r[0][i] :
                  s2_flags_r.second_col ? h_r[2][i] : h_r[4][i];
      win[i][1] = s2_flags_r.first_col  ? h_r[1][i] : h_r[3][i];
      win[i][2] = h_r[2][i];
      win[i][3] = s2_flags_r.last_col   ? h_r[3][i] : h_r[1][i];
      win[i][4] = s2_flags_r.last_col      ? h_r[4][i] :
                  s2_flags_r.next_last_col ? h_r[2][i] : h_r[0][i];
      for (int j = 0; j < WIN; j++) begin
        wv[i][j] = $signed(ACC_W'(win[i][j]));
      end
    end
    cen   = wv[2][2];
    far4  = wv[0][2] + wv[2][0] + wv[4][2] + wv[2][4];
    near4 = wv[1][2] + wv[3][2] + wv[2][1] + wv[2][3];
    diag  = wv[1][1] + wv[1][3] + wv[3][1] + wv[3][3];
    tg    = (cen <<< 3) - (far4 <<< 1) + (near4 <<< 2);
    t_oth = (cen <<< 3) + (cen <<< 2) - (far4 <<< 1) - far4 + (diag <<< 2);
    t_row = (cen <<< 3) + (cen <<< 1) - ((wv[2][0] + diag + wv[2][4]) <<< 1)
            + (wv[0][2] + wv[4][2]) + ((wv[2][1] + wv[2][3]) <<< 3);
    t_col = (cen <<< 3) + (cen <<< 1) - ((wv[0][2] + diag + wv[4][2]) <<< 1)
            + (wv[2][0] + wv[2][4]) + ((wv[1][2] + wv[3][2]) <<< 3);
    bd     = (bit_depth_r > 5'(PIXEL_BITS)) ? 5'(PIXEL_BITS) : bit_depth_r;
    maxv17 = ((OUT_W+1)'(1) << bd) - (OUT_W+1)'(1);
    maxv   = maxv17[OUT_W-1:0];
    f_cen  = finish(cen <<< 4, maxv);
    f_tg   = finish(tg, maxv);
    f_oth  = finish(t_oth, maxv);
    f_row  = finish(t_row, maxv);
    f_col  = finish(t_col, maxv);

    result.frame_last = s2_flags_r.frame_last;
    if (!enable_r) begin
      result.red   = OUT_W'(win[2][2]);
      result.green = OUT_W'(win[2][2]);
      result.blue  = OUT_W'(win[2][2]);
    end else if (s2_flags_r.odd_row == s2_flags_r.odd_col) begin
      result.green = f_tg;
      result.red   = s2_flags_r.odd_row ? f_oth : f_cen;
      result.blue  = s2_flags_r.odd_row ? f_cen : f_oth;
    end else begin
      result.green = f_cen;
      result.red   = s2_flags_r.odd_row ? f_col : f_row;
      result.blue  = s2_flags_r.odd_row ? f_row : f_col;
    end
  end

  // output queue
  localparam int QW = $clog2(FIFO_DEPTH);

  out_item_t       fifo_r [FIFO_DEPTH];
  logic [QW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QW:0]     cnt_r;
  logic            pop;
  logic [QW+1:0]   occupancy;

  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != '0;
  assign out_item  = fifo_r[rd_ptr_r];
  assign occupancy = (QW+2)'(cnt_r) + (QW+2)'(s1_valid_r) + (QW+2)'(s2_valid_r);
  assign in_stall  = occupancy >= (QW+2)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      fifo_r[wr_ptr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s2_valid_r) begin
        wr_ptr_r <= wr_ptr_r + QW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
      cnt_r <= cnt_r + (QW+1)'(s2_valid_r) - (QW+1)'(pop);
    end
  end

endmodule

FILE: src/bdm_ram.sv
// ----------------------------------------------------------------------------
// bdm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bdm_checker.sv
// ----------------------------------------------------------------------------
// bdm_checker
// port level checks of the bayer demosaic, bound to the top level
// ----------------------------------------------------------------------------
module bdm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input bdm_pkg::in_item_t             in_item,
  input logic                          out_valid,
  input logic                          out_stall,
  input bdm_pkg::out_item_t            out_item
);
  import bdm_pkg::*;

  logic out_beat;
  assign out_beat = out_valid && !out_stall;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_item.frame_last |=> !(out_beat && out_item.frame_last))
    else $error("frame end flagged on two beats in a row");

endmodule

bind bayer_demosaic_5x5 bdm_checker u_bdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: verif/bayer_demosaic_5x5_tb.sv
// ----------------------------------------------------------------------------
// bayer_demosaic_5x5_tb
// self-checking bench for the 5x5 bayer demosaic
// ----------------------------------------------------------------------------
// Streams raw bayer frames and flush beats into the block under random idling
// on both sides. A behavioral predictor keeps its own line stores, window
// geometry and register copy. Each result beat is checked field by field
// against the oldest predicted rgb beat. Covers bypass, every cfa layout,
// bit depth extremes, geometry clamps and restarts, back to back frames and a
// long output hold that fills the block.
// ----------------------------------------------------------------------------
module bayer_demosaic_5x5_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdm_pkg::*;

  localparam int LINE_MAX  = 4096;
  localparam int CYC_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bayer_demosaic_5x5 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [15:0] line_mem [8][LINE_MAX];
  int unsigned p_en, p_cfa, p_bd, p_fw, p_fh;
  int unsigned in_r, in_c, out_r, out_c, in_s, out_s, held;

  out_item_t pending_rgb[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic int unsigned width_used();
    int unsigned w;
    w = p_fw;
    if (w < 3) w = 3;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned height_used();
    return (p_fh < 3) ? 3 : p_fh;
  endfunction

  function automatic bit out_ready();
    int unsigned w, h;
    w = width_used();
    h = height_used();
    return (held >= 2 * w + 3) || (held >= w * h - (out_r * w + out_c));
  endfunction

  function automatic int fold(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic logic [15:0] scale_clip(int twice, int unsigned maxv);
    int unsigned v;
    if (twice < 0) return 16'd0;
    v = twice / 16;
    return (v > maxv) ? maxv[15:0] : v[15:0];
  endfunction

  task automatic restart_stream();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    in_s = 0; out_s = 0; held = 0;
  endtask

  task automatic predict_rgb(input in_item_t it);
    int unsigned w, h, left, bd, maxv, dy, dx, slot;
    int win [5][5];
    int r, c, rr, cen, far4, near4, diag, tg, to, t_row, t_col;
    out_item_t o;
    w = width_used();
    h = height_used();
    if (it.operation == OP_PIXEL) begin
      line_mem[in_s][in_c] = it.raw_pixel;
      held++;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_s = (in_s + 1) % 8;
        in_r++;
        if (in_r >= h) in_r = 0;
      end
    end
    left = w * h - (out_r * w + out_c);
    if (held < 2 * w + 3 && held < left) return;
    r = out_r;
    c = out_c;
    for (int i = 0; i < 5; i++) begin
      rr = fold(r + i - 2, h);
      slot = (out_s + 8 + rr - r) % 8;
      for (int j = 0; j < 5; j++) win[i][j] = line_mem[slot][fold(c + j - 2, w)];
    end
    cen = win[2][2];
    if (p_en == 0) begin
      o.red = cen[15:0]; o.green = cen[15:0]; o.blue = cen[15:0];
    end else begin
      bd = (p_bd > 16) ? 16 : p_bd;
      maxv = (1 << bd) - 1;
      dy = (out_r ^ (p_cfa >> 1)) & 1;
      dx = (out_c ^ ((p_cfa ^ (p_cfa >> 1)) & 1)) & 1;
      far4 = win[0][2] + win[2][0] + win[4][2] + win[2][4];
      near4 = win[1][2] + win[3][2] + win[2][1] + win[2][3];
      diag = win[1][1] + win[1][3] + win[3][1] + win[3][3];
      if (dy == dx) begin
        tg = 8 * cen - 2 * far4 + 4 * near4;
        to = 12 * cen - 3 * far4 + 4 * diag;
        o.green = scale_clip(tg, maxv);
        if (dy == 0) begin
          o.red = scale_clip(16 * cen, maxv); o.blue = scale_clip(to, maxv);
        end else begin
          o.blue = scale_clip(16 * cen, maxv); o.red = scale_clip(to, maxv);
        end
      end else begin
        t_row = 10 * cen - 2 * (win[2][0] + diag + win[2][4])
                + (win[0][2] + win[4][2]) + 8 * (win[2][1] + win[2][3]);
        t_col = 10 * cen - 2 * (win[0][2] + diag + win[4][2])
                + (win[2][0] + win[2][4]) + 8 * (win[1][2] + win[3][2]);
        o.green = scale_clip(16 * cen, maxv);
        if (dy == 0) begin
          o.red = scale_clip(t_row, maxv); o.blue = scale_clip(t_col, maxv);
        end else begin
          o.blue = scale_clip(t_row, maxv); o.red = scale_clip(t_col, maxv);
        end
      end
    end
    o.frame_last = (out_r == h - 1 && out_c == w - 1);
    pending_rgb.push_back(o);
    held--;
    out_c++;
    if (out_c >= w) begin
      out_c = 0;
      out_s = (out_s + 1) % 8;
      out_r++;
      if (out_r >= h) out_r = 0;
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  // result checker
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        report("unexpected beat", int'(out_item.red), 0);
      end else begin
        out_item_t e;
        e = pending_rgb.pop_front();
        if (out_item.red !== e.red) report("red", int'(out_item.red), int'(e.red));
        if (out_item.green !== e.green)
          report("green", int'(out_item.green), int'(e.green));
        if (out_item.blue !== e.blue) report("blue", int'(out_item.blue), int'(e.blue));
        if (out_item.frame_last !== e.frame_last)
          report("frame_last", int'(out_item.frame_last), int'(e.frame_last));
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = (idle_on && out_valid && !out_stall) ? $urandom_range(0, 12) : 0;
      out_stall <= (idle_on && $urandom_range(0, 7) == 0);
    end
  end

  task automatic send_beat(input op_e op, input logic [15:0] px);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{operation: op, raw_pixel: px};
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_rgb('{operation: op, raw_pixel: px});
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:       p_en = val & 1;
      CFG_CFA_PATTERN:  p_cfa = val & 3;
      CFG_BIT_DEPTH:    p_bd = val & 31;
      CFG_FRAME_WIDTH:  begin p_fw = val & 13'h1fff; restart_stream(); end
      CFG_FRAME_HEIGHT: begin p_fh = val & 14'h3fff; restart_stream(); end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, (1 << ((p_bd > 16 || p_bd == 0) ? 16 : p_bd)) - 1));
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic send_frame(input int unsigned n_px);
    for (int unsigned k = 0; k < n_px; k++) send_beat(OP_PIXEL, pick_pixel());
  endtask

  task automatic drain();
    while (held > 0 && out_ready()) send_beat(OP_FLUSH, 16'($urandom_range(0, 16'hffff)));
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  task automatic test_bypass();
    set_geometry(4, 3);
    send_beat(OP_FLUSH, 16'hffff);
    for (int k = 0; k < 12; k++) send_beat(OP_PIXEL, (k % 2) ? 16'hffff : 16'h0000);
    drain();
    send_beat(OP_FLUSH, 16'h0000);
    settle();
  endtask

  task automatic test_cfa_layouts();
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_BIT_DEPTH, 16);
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_CFA_PATTERN, p);
      set_geometry(5, 4);
      send_frame(20);
      drain();
      settle();
    end
  endtask

  task automatic test_bit_depth();
    int unsigned depths [6] = '{0, 1, 8, 16, 17, 31};
    foreach (depths[d]) begin
      write_reg(CFG_BIT_DEPTH, depths[d]);
      write_reg(CFG_CFA_PATTERN, $urandom_range(0, 3));
      set_geometry(4, 4);
      send_frame(16);
      drain();
      settle();
    end
    write_reg(CFG_BIT_DEPTH, 12);
  endtask

  task automatic test_geometry();
    set_geometry(0, 0);
    send_frame(9);
    drain();
    settle();
    set_geometry(1, 16383);
    send_frame(20);
    settle();
    set_geometry(3, 3);
    send_frame(9);
    drain();
    settle();
    idle_on = 1'b0;
    set_geometry(8191, 3);
    send_frame(24);
    drain();
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    set_geometry(6, 3);
    for (int f = 0; f < 4; f++) send_frame(18);
    drain();
    settle();
  endtask

  task automatic test_backpressure();
    set_geometry(5, 5);
    idle_on = 1'b0;
    hold_req = 1'b1;
    send_frame(75);
    drain();
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    int unsigned w, h, n;
    sent = 0;
    while (sent < 350) begin
      write_reg(CFG_ENABLE, ($urandom_range(0, 3) != 0));
      write_reg(CFG_CFA_PATTERN, $urandom_range(0, 3));
      write_reg(CFG_BIT_DEPTH, $urandom_range(0, 31));
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 6);
      set_geometry(w, h);
      idle_on = ($urandom_range(0, 4) != 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : w * h;
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 15) == 0)
            send_beat(OP_FLUSH, 16'($urandom_range(0, 16'hffff)));
          else send_beat(OP_PIXEL, pick_pixel());
        end
        sent += n;
      end
      if ($urandom_range(0, 1)) drain();
      settle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    p_en = 0; p_cfa = 0; p_bd = 12; p_fw = 1920; p_fh = 1080;
    restart_stream();
    foreach (line_mem[s, k]) line_mem[s][k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_bypass();
    test_cfa_layouts();
    test_bit_depth();
    test_geometry();
    test_back_to_back();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
